### sv/pli_pkg.sv
package pli_pkg;

   localparam int MaxPoints = 16;
   localparam int DataWidth = 32;
   localparam int CountWidth = 5;
   localparam int IndexWidth = 4;
   localparam int CsrAddrWidth = 1;

   // Request kinds.
   localparam logic ReqLoad = 1'b0;
   localparam logic ReqQuery = 1'b1;

   // Register addresses.
   localparam logic [CsrAddrWidth-1:0] CsrPointsInUse = 1'b0;

   // Divider sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } div_state_type;

   // Interpolation job handed from the front end to the back end.
   typedef struct packed {
      logic        direct;
      logic [31:0] y0;
      logic [31:0] dx;
      logic [31:0] dy_mag;
      logic        dy_neg;
      logic [32:0] width;
   } job_type;

endpackage

### sv/pli_front.sv
module pli_front #(
   parameter int MAX_POINTS = pli_pkg::MaxPoints
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_kind,
   input  logic [3:0]          in_index,
   input  logic signed [31:0]  in_ex,
   input  logic signed [31:0]  in_ey,
   input  logic signed [31:0]  in_qx,
   input  logic [4:0]          points_in_use,
   output logic                job_valid,
   output pli_pkg::job_type    job
);

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic signed [31:0] bx_ff [MAX_POINTS];
   logic signed [31:0] by_ff [MAX_POINTS];

   logic [CW-1:0] n;
   logic [CW-1:0] idx;
   logic [IW-1:0] i0, i1;
   logic          direct;
   logic signed [31:0] y0, y1;
   logic signed [32:0] dy;
   pli_pkg::job_type job_in;

   // Table write on a load beat.
   always_ff @(posedge clock) begin
      if (in_valid && in_kind == pli_pkg::ReqLoad && 32'(in_index) < MAX_POINTS) begin
         bx_ff[IW'(in_index)] <= in_ex;
         by_ff[IW'(in_index)] <= in_ey;
      end
   end

   // Effective count clamped to the table size; a count of zero is taken as one.
   always_comb begin
      if (points_in_use == 5'd0) begin
         n = CW'(1);
      end else if (32'(points_in_use) > MAX_POINTS) begin
         n = CW'(MAX_POINTS);
      end else begin
         n = CW'(points_in_use);
      end
   end

   // Linear search for the first in-use breakpoint whose x exceeds the query, even on unsorted tables.
   always_comb begin
      idx = n;
      for (int k = MAX_POINTS - 1; k >= 0; k--) begin
         if (k < 32'(n) && in_qx < bx_ff[k]) begin
            idx = CW'(k);
         end
      end
   end

   always_comb begin
      direct = 1'b0;
      i0 = '0;
      i1 = '0;
      if (idx == '0) begin
         direct = 1'b1;
      end else if (idx == n) begin
         direct = 1'b1;
         i0 = IW'(n - CW'(1));
      end else begin
         i0 = IW'(idx - CW'(1));
         i1 = IW'(idx);
      end
      y0 = by_ff[i0];
      y1 = by_ff[i1];
      dy = 33'(y1) - 33'(y0);
      job_in.direct = direct;
      job_in.y0 = y0;
      job_in.dx = 32'(33'(in_qx) - 33'(bx_ff[i0]));
      job_in.dy_neg = dy[32];
      job_in.dy_mag = dy[32] ? 32'(-dy) : 32'(dy);
      job_in.width = 33'(bx_ff[i1]) - 33'(bx_ff[i0]);
   end

   logic job_valid_ff;
   pli_pkg::job_type job_ff;

   // Register the classified job.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= in_valid && in_kind == pli_pkg::ReqQuery;
      end
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job = job_ff;

endmodule

### sv/pli_back.sv
module pli_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  pli_pkg::job_type  job,
   output logic              job_ready,
   output logic              res_valid,
   output logic [31:0]       res_value,
   input  logic              res_ready
);

   pli_pkg::div_state_type state_ff, state_in;
   pli_pkg::job_type job_ff;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] value_ff, value_in;
   logic        load_job;
   logic [33:0] trial;

   // Restoring divider, one quotient bit per cycle.
   always_comb begin
      state_in = state_ff;
      prod_in = prod_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      value_in = value_ff;
      load_job = 1'b0;
      job_ready = 1'b0;
      res_valid = 1'b0;
      trial = {rem_ff, prod_ff[63]} - {1'b0, job_ff.width};
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               load_job = 1'b1;
               state_in = job.direct ? pli_pkg::ST_DONE : pli_pkg::ST_MULT;
               value_in = job.y0;
            end
         end
         pli_pkg::ST_MULT: begin
            prod_in = 64'(job_ff.dx) * 64'(job_ff.dy_mag);
            rem_in = '0;
            quot_in = '0;
            cnt_in = '0;
            state_in = pli_pkg::ST_DIV;
         end
         pli_pkg::ST_DIV: begin
            if (!trial[33]) begin
               rem_in = trial[32:0];
               quot_in = {quot_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], prod_ff[63]};
               quot_in = {quot_ff[62:0], 1'b0};
            end
            prod_in = {prod_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               value_in = job_ff.dy_neg ? job_ff.y0 - quot_in[31:0]
                                        : job_ff.y0 + quot_in[31:0];
               state_in = pli_pkg::ST_DONE;
            end
         end
         pli_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (load_job) begin
         job_ff <= job;
      end
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      value_ff <= value_in;
   end

   assign res_value = value_ff;

endmodule

### sv/pli_fifo.sv
module pli_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  logic [WIDTH-1:0] wr_data,
   output logic             wr_ready,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data,
   input  logic             rd_ready
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic wr, rd;

   assign wr_ready = cnt_ff != (AW+1)'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   assign rd_data = mem_ff[rp_ff];

   // Small register queue between the two sides.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) begin
            wp_ff <= (32'(wp_ff) == DEPTH - 1) ? '0 : wp_ff + AW'(1);
         end
         if (rd) begin
            rp_ff <= (32'(rp_ff) == DEPTH - 1) ? '0 : rp_ff + AW'(1);
         end
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
      if (wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

### sv/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator core.
// Input channel: push a beat while full is low. req_type 0 loads breakpoint
// entry_index with (entry_x, entry_y); req_type 1 queries at query_x.
// Loads give no result. Each query gives one result beat on rsp_result_value,
// valid while rsp_empty is low and retired with rsp_pop.
// The front end compares the query with all breakpoints combinationally
// and writes an interpolation job into a four-beat queue. The back end forms
// the product in ST_MULT, then runs a restoring divider at one quotient
// bit per cycle; a clamped query skips both and goes straight to ST_DONE.
// The back end takes a new query only after it has handed the last result
// to the output queue; loads are taken at one per cycle while req_full is low.
// Results wait in a four-beat output queue, so a stalled receiver first
// fills that queue, then the job queue, and then raises req_full.
// Reset (synchronous, active high) empties all queues and sets
// points_in_use to 1; breakpoints are undefined until loaded.
// Register points_in_use is at csr address 0.
module piecewise_linear_interpolator_core #(
   parameter int MAX_POINTS = pli_pkg::MaxPoints
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_type,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_entry_x,
   input  logic signed [31:0] req_entry_y,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_result_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [0:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int JW = $bits(pli_pkg::job_type);

   logic [4:0] piu_ff;
   logic accept;
   logic job_valid, jq_ready, jq_valid, back_ready, res_valid, rq_ready;
   pli_pkg::job_type job, job_q;
   logic [31:0] res_value;
   logic rq_valid;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == pli_pkg::CsrPointsInUse) ? 32'(piu_ff) : '0;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         piu_ff <= 5'd1;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == pli_pkg::CsrPointsInUse) begin
         piu_ff <= csr_pwdata[4:0];
      end
   end

   // Push accepted while the job queue has room.
   assign req_full = !jq_ready;
   assign accept = req_push && jq_ready;

   pli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock(clock), .reset(reset), .in_valid(accept), .in_kind(req_type),
      .in_index(req_entry_index), .in_ex(req_entry_x), .in_ey(req_entry_y),
      .in_qx(req_query_x), .points_in_use(piu_ff),
      .job_valid(job_valid), .job(job)
   );

   // Job count also covers the job still registered in the front end, so the
   // queue never overflows.
   logic jq_wr_ready;
   logic [2:0] jq_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         jq_cnt_ff <= '0;
      end else begin
         jq_cnt_ff <= jq_cnt_ff + 3'(accept && req_type == pli_pkg::ReqQuery)
                      - 3'(jq_valid && back_ready);
      end
   end
   assign jq_ready = jq_cnt_ff < 3'd4;

   pli_fifo #(.WIDTH(JW), .DEPTH(4)) u_jobq (
      .clock(clock), .reset(reset), .wr_valid(job_valid), .wr_data(job),
      .wr_ready(jq_wr_ready), .rd_valid(jq_valid), .rd_data(job_q),
      .rd_ready(back_ready)
   );

   // Back end only starts a job when the result queue has room for it.
   logic [2:0] rq_cnt_ff;
   logic back_take;
   assign back_take = jq_valid && back_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rq_cnt_ff <= '0;
      end else begin
         rq_cnt_ff <= rq_cnt_ff + 3'(back_take) - 3'(!rsp_empty && rsp_pop);
      end
   end

   logic be_ready;
   assign back_ready = be_ready && rq_cnt_ff < 3'd4;

   pli_back u_back (
      .clock(clock), .reset(reset), .job_valid(jq_valid && rq_cnt_ff < 3'd4),
      .job(job_q), .job_ready(be_ready), .res_valid(res_valid),
      .res_value(res_value), .res_ready(rq_ready)
   );

   pli_fifo #(.WIDTH(32), .DEPTH(4)) u_rspq (
      .clock(clock), .reset(reset), .wr_valid(res_valid), .wr_data(res_value),
      .wr_ready(rq_ready), .rd_valid(rq_valid), .rd_data(rsp_result_value),
      .rd_ready(rsp_pop)
   );

   assign rsp_empty = !rq_valid;

   logic unused_ok;
   assign unused_ok = jq_wr_ready;

endmodule
